// ===== rtl/drp_pkg.sv =====
// shared widths, types and helpers for the drucker-prager stress return
// no dependencies
package drp_pkg;

  // field widths
  localparam int SW = 48;            // stress
  localparam int EW = 40;            // strain
  localparam int LW = 37;            // lame constants
  localparam int TW = 17;            // trig factors q1.16
  localparam int CW = SW - 1;        // cohesion

  // register indexes on the configuration port
  localparam logic [2:0] REG_LAMBDA = 3'd0;
  localparam logic [2:0] REG_SHEAR  = 3'd1;
  localparam logic [2:0] REG_IXX    = 3'd2;
  localparam logic [2:0] REG_IYY    = 3'd3;
  localparam logic [2:0] REG_IXY    = 3'd4;
  localparam logic [2:0] REG_COH    = 3'd5;
  localparam logic [2:0] REG_COS    = 3'd6;
  localparam logic [2:0] REG_SIN    = 3'd7;
  localparam int IDXW = 3;
  localparam logic [TW-1:0] COS_RESET = TW'(65536);

  // elastic increment
  localparam int DW = EW + 1;        // strain difference
  localparam int KW = LW + 2;        // lambda + 2 mu
  localparam int KLO = 20;           // split point of the modulus
  localparam int KHI = KW - KLO;
  localparam int PLW = DW + KLO + 1;
  localparam int PHW = DW + KHI + 1;
  localparam int ACCW = DW + KW + 3;
  localparam int FRAC_SH = 32;
  localparam int INCW = ACCW - FRAC_SH;
  localparam logic signed [ACCW-1:0] INC_RND = ACCW'(1) <<< (FRAC_SH - 1);

  // yield test
  localparam int S2W = SW + 1;
  localparam int LCW = CW + TW + 1;
  localparam int LSW = S2W + TW + 1;
  localparam int LRW = LSW + 2;
  localparam int LIMW = 52;
  localparam int LIM_SH = 16;
  localparam logic signed [LRW-1:0] LIM_RND = LRW'(1) <<< (LIM_SH - 1);
  localparam int SQS = SW / 2;       // split of the squares
  localparam int DQW = SW + SQS;
  localparam int QW = 2 * SW + 2;
  localparam int LLO = LIMW / 2;
  localparam int L2PW = LIMW + LLO;
  localparam int L2W = 2 * LIMW;

  // square root and scaling
  localparam int RTW = SW + 1;       // root bits
  localparam int SQRW = QW + 2;
  localparam int MLO = 25;           // split of the limit in the scaling product
  localparam int MLW = SW + MLO;
  localparam int MHW = SW + RTW - MLO;
  localparam int NW = SW + RTW + 1;  // dividend
  localparam int QB = RTW + 2;       // quotient bits
  localparam int RW = RTW + 1;       // partial remainder

  localparam int FIFO_DEPTH = 4;
  localparam int FAW = 2;

  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  typedef struct packed {
    logic [LW-1:0]        lam;
    logic [LW-1:0]        shear;
    logic signed [SW-1:0] ixx;
    logic signed [SW-1:0] iyy;
    logic signed [SW-1:0] ixy;
    logic [CW-1:0]        coh;
    logic [TW-1:0]        fcos;
    logic [TW-1:0]        fsin;
  } drp_cfg_t;

  typedef struct packed {
    logic signed [SW-1:0]  px;
    logic signed [SW-1:0]  py;
    logic signed [SW-1:0]  ps;
    logic signed [S2W-1:0] sum2;
    logic [SW-1:0]         dmag;
    logic                  dneg;
    logic [SW-1:0]         smag;
    logic                  sneg;
    logic [LIMW-1:0]       lim;
    logic [QW-1:0]         q;
    logic                  yld;
  } drp_item_t;

  function automatic logic signed [SW-1:0] sat_stress(input logic signed [63:0] a);
    logic signed [SW-1:0] r;
    if (a > SMAX) r = SMAX[SW-1:0];
    else if (a < SMIN) r = SMIN[SW-1:0];
    else r = a[SW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/drp_front.sv =====
// front end: elastic trial stress, shear measure, yield limit and yield decision
// depends on drp_pkg
module drp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [drp_pkg::EW-1:0] strain_xx,
  input  logic signed [drp_pkg::EW-1:0] strain_yy,
  input  logic signed [drp_pkg::EW-1:0] strain_xy,
  input  logic signed [drp_pkg::EW-1:0] prev_strain_xx,
  input  logic signed [drp_pkg::EW-1:0] prev_strain_yy,
  input  logic signed [drp_pkg::EW-1:0] prev_strain_xy,
  input  logic signed [drp_pkg::SW-1:0] prev_stress_xx,
  input  logic signed [drp_pkg::SW-1:0] prev_stress_yy,
  input  logic signed [drp_pkg::SW-1:0] prev_stress_xy,
  input  drp_pkg::drp_cfg_t             cfg,
  output logic                          push,
  output drp_pkg::drp_item_t            item
);

  logic [7:0] v_r;

  // stage 1: strain increments
  logic signed [drp_pkg::DW-1:0] g_r [3];
  logic signed [drp_pkg::SW-1:0] p1_r [3];
  // stage 2: split products
  logic [drp_pkg::KW-1:0]         kv [5];
  logic signed [drp_pkg::DW-1:0]  gsel [5];
  logic signed [drp_pkg::PLW-1:0] plo_r [5];
  logic signed [drp_pkg::PHW-1:0] phi_r [5];
  logic signed [drp_pkg::SW-1:0]  p2_r [3];
  // stage 3: increments
  logic signed [drp_pkg::ACCW-1:0] full [5];
  logic signed [drp_pkg::ACCW-1:0] acc [3];
  logic signed [drp_pkg::INCW-1:0] inc_r [3];
  logic signed [drp_pkg::SW-1:0]   p3_r [3];
  // stage 4: trial stress
  logic signed [drp_pkg::SW-1:0] t_r [3];
  logic signed [drp_pkg::SW-1:0] ini [3];
  // stage 5 onward
  drp_pkg::drp_item_t it5_r, it6_r, it7_r, it8_r;
  drp_pkg::drp_item_t it6_nxt, it7_nxt, it8_nxt;
  logic signed [drp_pkg::S2W-1:0] dif;
  logic [drp_pkg::LCW-1:0]        lc_r;
  logic signed [drp_pkg::LSW-1:0] ls_r;
  logic signed [drp_pkg::LRW-1:0] lraw;
  logic [drp_pkg::DQW-1:0]        dqlo_r, dqhi_r, sqlo_r, sqhi_r;
  logic [drp_pkg::L2PW-1:0]       l2lo_r, l2hi_r;
  logic [drp_pkg::L2W-1:0]        l2;
  logic [drp_pkg::KW-1:0]         k1;

  assign ini[0] = cfg.ixx;
  assign ini[1] = cfg.iyy;
  assign ini[2] = cfg.ixy;

  assign k1 = {2'b00, cfg.lam} + {1'b0, cfg.shear, 1'b0};

  always_comb begin
    kv[0] = k1;
    kv[1] = {2'b00, cfg.lam};
    kv[2] = {2'b00, cfg.lam};
    kv[3] = k1;
    kv[4] = {2'b00, cfg.shear};
    gsel[0] = g_r[0];
    gsel[1] = g_r[1];
    gsel[2] = g_r[0];
    gsel[3] = g_r[1];
    gsel[4] = g_r[2];
    for (int i = 0; i < 5; i++) begin
      full[i] = (drp_pkg::ACCW'(phi_r[i]) <<< drp_pkg::KLO) + drp_pkg::ACCW'(plo_r[i]);
    end
    acc[0] = full[0] + full[1] + drp_pkg::INC_RND;
    acc[1] = full[2] + full[3] + drp_pkg::INC_RND;
    acc[2] = full[4] + drp_pkg::INC_RND;
    dif = drp_pkg::S2W'(t_r[0]) - drp_pkg::S2W'(t_r[1]);
    lraw = drp_pkg::LRW'($signed({1'b0, lc_r})) - drp_pkg::LRW'(ls_r) + drp_pkg::LIM_RND;
    l2 = (drp_pkg::L2W'(l2hi_r) << drp_pkg::LLO) + drp_pkg::L2W'(l2lo_r);
    // stage 6: limit clamp
    it6_nxt = it5_r;
    it6_nxt.lim = lraw[drp_pkg::LRW-1] ? '0 : lraw[drp_pkg::LIM_SH +: drp_pkg::LIMW];
    // stage 7: shear measure
    it7_nxt = it6_r;
    it7_nxt.q = (drp_pkg::QW'(dqhi_r) << drp_pkg::SQS) + drp_pkg::QW'(dqlo_r)
              + (((drp_pkg::QW'(sqhi_r) << drp_pkg::SQS) + drp_pkg::QW'(sqlo_r)) << 2);
    // stage 8: yield decision
    it8_nxt = it7_r;
    it8_nxt.yld = drp_pkg::L2W'(it7_r.q) > l2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[6:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    g_r[0] <= drp_pkg::DW'(strain_xx) - drp_pkg::DW'(prev_strain_xx);
    g_r[1] <= drp_pkg::DW'(strain_yy) - drp_pkg::DW'(prev_strain_yy);
    g_r[2] <= drp_pkg::DW'(strain_xy) - drp_pkg::DW'(prev_strain_xy);
    p1_r[0] <= prev_stress_xx;
    p1_r[1] <= prev_stress_yy;
    p1_r[2] <= prev_stress_xy;
    // stage 2
    for (int i = 0; i < 5; i++) begin
      plo_r[i] <= gsel[i] * $signed({1'b0, kv[i][drp_pkg::KLO-1:0]});
      phi_r[i] <= gsel[i] * $signed({1'b0, kv[i][drp_pkg::KW-1:drp_pkg::KLO]});
    end
    p2_r <= p1_r;
    // stage 3
    for (int i = 0; i < 3; i++) begin
      inc_r[i] <= acc[i][drp_pkg::ACCW-1:drp_pkg::FRAC_SH];
    end
    p3_r <= p2_r;
    // stage 4
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= drp_pkg::sat_stress(64'(inc_r[i]) + 64'(p3_r[i]) + 64'(ini[i]));
    end
    // stage 5: mean, deviator, limit products
    it5_r.px   <= t_r[0];
    it5_r.py   <= t_r[1];
    it5_r.ps   <= t_r[2];
    it5_r.sum2 <= drp_pkg::S2W'(t_r[0]) + drp_pkg::S2W'(t_r[1]);
    it5_r.dneg <= dif[drp_pkg::S2W-1];
    it5_r.dmag <= dif[drp_pkg::S2W-1] ? drp_pkg::SW'(-dif) : drp_pkg::SW'(dif);
    it5_r.sneg <= t_r[2][drp_pkg::SW-1];
    it5_r.smag <= t_r[2][drp_pkg::SW-1] ? drp_pkg::SW'(-t_r[2]) : drp_pkg::SW'(t_r[2]);
    it5_r.lim  <= '0;
    it5_r.q    <= '0;
    it5_r.yld  <= 1'b0;
    lc_r <= cfg.coh * {cfg.fcos, 1'b0};
    ls_r <= (drp_pkg::S2W'(t_r[0]) + drp_pkg::S2W'(t_r[1])) * $signed({1'b0, cfg.fsin});
    // stage 6: limit clamp, split squares
    it6_r <= it6_nxt;
    dqlo_r <= it5_r.dmag * it5_r.dmag[drp_pkg::SQS-1:0];
    dqhi_r <= it5_r.dmag * it5_r.dmag[drp_pkg::SW-1:drp_pkg::SQS];
    sqlo_r <= it5_r.smag * it5_r.smag[drp_pkg::SQS-1:0];
    sqhi_r <= it5_r.smag * it5_r.smag[drp_pkg::SW-1:drp_pkg::SQS];
    // stage 7: shear measure, split limit square
    it7_r <= it7_nxt;
    l2lo_r <= it6_r.lim * it6_r.lim[drp_pkg::LLO-1:0];
    l2hi_r <= it6_r.lim * it6_r.lim[drp_pkg::LIMW-1:drp_pkg::LLO];
    // stage 8: yield decision
    it8_r <= it8_nxt;
  end

  assign push = v_r[7];
  assign item = it8_r;

endmodule

// ===== rtl/drp_fifo.sv =====
// short transaction queue between the front and back ends
// depends on drp_pkg
module drp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  drp_pkg::drp_item_t din,
  output logic               pop,
  output drp_pkg::drp_item_t dout,
  output logic               afull
);

  drp_pkg::drp_item_t mem [drp_pkg::FIFO_DEPTH];
  logic [drp_pkg::FAW-1:0] wp_r, rp_r;
  logic [drp_pkg::FAW:0]   cnt_r, cnt_nxt;

  // back end drains one transaction a cycle whenever one is queued
  assign pop   = cnt_r != '0;
  assign dout  = mem[rp_r];
  assign afull = cnt_r >= (drp_pkg::FAW + 1)'(drp_pkg::FIFO_DEPTH - 1);

  always_comb begin
    cnt_nxt = cnt_r + (drp_pkg::FAW + 1)'(push) - (drp_pkg::FAW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == (drp_pkg::FAW + 1)'(drp_pkg::FIFO_DEPTH)))
    else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (drp_pkg::FAW + 1)'(drp_pkg::FIFO_DEPTH))
    else $error("queue count out of range");
  a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> cnt_r != '0)
    else $error("pushed transaction lost");

endmodule

// ===== rtl/drp_back.sv =====
// back end: pipelined square root, scaling divides and output saturation
// depends on drp_pkg
module drp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_v,
  input  drp_pkg::drp_item_t            in_item,
  input  drp_pkg::drp_cfg_t             cfg,
  output logic                          out_v,
  output logic signed [drp_pkg::SW-1:0] o_xx,
  output logic signed [drp_pkg::SW-1:0] o_yy,
  output logic signed [drp_pkg::SW-1:0] o_xy,
  output logic                          o_yld
);

  // square root pipeline, one root bit per stage
  logic                     sv_r    [drp_pkg::RTW+1];
  drp_pkg::drp_item_t       sit_r   [drp_pkg::RTW+1];
  logic [drp_pkg::SQRW-1:0] srem_r  [drp_pkg::RTW+1];
  logic [drp_pkg::RTW-1:0]  sroot_r [drp_pkg::RTW+1];
  logic [drp_pkg::SQRW-1:0] srem_n  [drp_pkg::RTW];
  logic [drp_pkg::RTW-1:0]  sroot_n [drp_pkg::RTW];
  logic [drp_pkg::SQRW-1:0] strial  [drp_pkg::RTW];

  // scaling products
  logic                    m1v_r, m2v_r;
  drp_pkg::drp_item_t      m1it_r, m2it_r;
  logic [drp_pkg::RTW-1:0] m1t_r, m2t_r;
  logic [drp_pkg::MLW-1:0] dlo_r, slo_r;
  logic [drp_pkg::MHW-1:0] dhi_r, shi_r;
  logic [drp_pkg::NW-1:0]  dn_r, sn_r;

  // dividers, one quotient bit per stage
  logic                    dv_r  [drp_pkg::QB+1];
  drp_pkg::drp_item_t      dit_r [drp_pkg::QB+1];
  logic [drp_pkg::RTW-1:0] dt_r  [drp_pkg::QB+1];
  logic [drp_pkg::NW-1:0]  ddn_r [drp_pkg::QB+1];
  logic [drp_pkg::NW-1:0]  dsn_r [drp_pkg::QB+1];
  logic [drp_pkg::RW-1:0]  ddr_r [drp_pkg::QB+1];
  logic [drp_pkg::RW-1:0]  dsr_r [drp_pkg::QB+1];
  logic [drp_pkg::QB-1:0]  ddq_r [drp_pkg::QB+1];
  logic [drp_pkg::QB-1:0]  dsq_r [drp_pkg::QB+1];
  logic [drp_pkg::RW-1:0]  ddr_n [drp_pkg::QB];
  logic [drp_pkg::RW-1:0]  dsr_n [drp_pkg::QB];
  logic [drp_pkg::QB-1:0]  ddq_n [drp_pkg::QB];
  logic [drp_pkg::QB-1:0]  dsq_n [drp_pkg::QB];

  drp_pkg::drp_item_t      fit;
  logic signed [63:0]      qd, qs, dp, sp, ox, oy;

  always_comb begin
    for (int k = 0; k < drp_pkg::RTW; k++) begin
      strial[k] = (drp_pkg::SQRW'(sroot_r[k]) << (drp_pkg::RTW - k))
                + (drp_pkg::SQRW'(1) << (2 * (drp_pkg::RTW - 1 - k)));
      srem_n[k]  = srem_r[k];
      sroot_n[k] = sroot_r[k];
      if (srem_r[k] >= strial[k]) begin
        srem_n[k] = srem_r[k] - strial[k];
        sroot_n[k][drp_pkg::RTW-1-k] = 1'b1;
      end
    end
    for (int k = 0; k < drp_pkg::QB; k++) begin
      ddr_n[k] = {ddr_r[k][drp_pkg::RW-2:0], ddn_r[k][drp_pkg::QB-1-k]};
      dsr_n[k] = {dsr_r[k][drp_pkg::RW-2:0], dsn_r[k][drp_pkg::QB-1-k]};
      ddq_n[k] = ddq_r[k];
      dsq_n[k] = dsq_r[k];
      if (ddr_n[k] >= drp_pkg::RW'(dt_r[k])) begin
        ddr_n[k] = ddr_n[k] - drp_pkg::RW'(dt_r[k]);
        ddq_n[k][drp_pkg::QB-1-k] = 1'b1;
      end
      if (dsr_n[k] >= drp_pkg::RW'(dt_r[k])) begin
        dsr_n[k] = dsr_n[k] - drp_pkg::RW'(dt_r[k]);
        dsq_n[k][drp_pkg::QB-1-k] = 1'b1;
      end
    end
    fit = dit_r[drp_pkg::QB];
    qd = 64'($signed({1'b0, ddq_r[drp_pkg::QB]}));
    qs = 64'($signed({1'b0, dsq_r[drp_pkg::QB]}));
    dp = fit.dneg ? -qd : qd;
    sp = fit.sneg ? -qs : qs;
    ox = (64'(fit.sum2) + dp + 64'sd1) >>> 1;
    oy = (64'(fit.sum2) - dp + 64'sd1) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= drp_pkg::RTW; k++) sv_r[k] <= 1'b0;
      for (int k = 0; k <= drp_pkg::QB; k++) dv_r[k] <= 1'b0;
      m1v_r <= 1'b0;
      m2v_r <= 1'b0;
      out_v <= 1'b0;
    end else begin
      sv_r[0] <= in_v;
      for (int k = 0; k < drp_pkg::RTW; k++) sv_r[k+1] <= sv_r[k];
      m1v_r <= sv_r[drp_pkg::RTW];
      m2v_r <= m1v_r;
      dv_r[0] <= m2v_r;
      for (int k = 0; k < drp_pkg::QB; k++) dv_r[k+1] <= dv_r[k];
      out_v <= dv_r[drp_pkg::QB];
    end
  end

  always_ff @(posedge clk) begin
    sit_r[0]   <= in_item;
    srem_r[0]  <= drp_pkg::SQRW'(in_item.q);
    sroot_r[0] <= '0;
    for (int k = 0; k < drp_pkg::RTW; k++) begin
      sit_r[k+1]   <= sit_r[k];
      srem_r[k+1]  <= srem_n[k];
      sroot_r[k+1] <= sroot_n[k];
    end
    // scaling products, limit split in two halves
    m1it_r <= sit_r[drp_pkg::RTW];
    m1t_r  <= sroot_r[drp_pkg::RTW];
    dlo_r <= sit_r[drp_pkg::RTW].dmag * sit_r[drp_pkg::RTW].lim[drp_pkg::MLO-1:0];
    dhi_r <= sit_r[drp_pkg::RTW].dmag * sit_r[drp_pkg::RTW].lim[drp_pkg::RTW-1:drp_pkg::MLO];
    slo_r <= sit_r[drp_pkg::RTW].smag * sit_r[drp_pkg::RTW].lim[drp_pkg::MLO-1:0];
    shi_r <= sit_r[drp_pkg::RTW].smag * sit_r[drp_pkg::RTW].lim[drp_pkg::RTW-1:drp_pkg::MLO];
    m2it_r <= m1it_r;
    m2t_r  <= m1t_r;
    // dividend with half the divisor added for round to nearest
    dn_r <= (drp_pkg::NW'(dhi_r) << drp_pkg::MLO) + drp_pkg::NW'(dlo_r)
          + drp_pkg::NW'(m1t_r >> 1);
    sn_r <= (drp_pkg::NW'(shi_r) << drp_pkg::MLO) + drp_pkg::NW'(slo_r)
          + drp_pkg::NW'(m1t_r >> 1);
    // dividers
    dit_r[0] <= m2it_r;
    dt_r[0]  <= m2t_r;
    ddn_r[0] <= dn_r;
    dsn_r[0] <= sn_r;
    ddr_r[0] <= drp_pkg::RW'(dn_r >> drp_pkg::QB);
    dsr_r[0] <= drp_pkg::RW'(sn_r >> drp_pkg::QB);
    ddq_r[0] <= '0;
    dsq_r[0] <= '0;
    for (int k = 0; k < drp_pkg::QB; k++) begin
      dit_r[k+1] <= dit_r[k];
      dt_r[k+1]  <= dt_r[k];
      ddn_r[k+1] <= ddn_r[k];
      dsn_r[k+1] <= dsn_r[k];
      ddr_r[k+1] <= ddr_n[k];
      dsr_r[k+1] <= dsr_n[k];
      ddq_r[k+1] <= ddq_n[k];
      dsq_r[k+1] <= dsq_n[k];
    end
    // remove initial stress and saturate
    o_yld <= fit.yld;
    if (fit.yld) begin
      o_xx <= drp_pkg::sat_stress(ox - 64'(cfg.ixx));
      o_yy <= drp_pkg::sat_stress(oy - 64'(cfg.iyy));
      o_xy <= drp_pkg::sat_stress(sp - 64'(cfg.ixy));
    end else begin
      o_xx <= drp_pkg::sat_stress(64'(fit.px) - 64'(cfg.ixx));
      o_yy <= drp_pkg::sat_stress(64'(fit.py) - 64'(cfg.iyy));
      o_xy <= drp_pkg::sat_stress(64'(fit.ps) - 64'(cfg.ixy));
    end
  end

endmodule

// ===== rtl/drucker_prager_stress_return.sv =====
// top level of the plane-strain drucker-prager stress return
// depends on drp_pkg, drp_front, drp_fifo, drp_back
// pipeline: 8 front stages, 1 queue slot, 50 square-root stages, 2 product stages,
//   52 divider stages, output register
// throughput: one transaction per cycle; the bit-serial root and dividers are fully pipelined
// reset: synchronous active-low rst_n clears all valid bits and loads the register defaults
// results appear on out_valid for one cycle and cannot be stalled
module drucker_prager_stress_return (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [drp_pkg::EW-1:0]   in_strain_xx,
  input  logic signed [drp_pkg::EW-1:0]   in_strain_yy,
  input  logic signed [drp_pkg::EW-1:0]   in_strain_xy,
  input  logic signed [drp_pkg::EW-1:0]   in_prev_strain_xx,
  input  logic signed [drp_pkg::EW-1:0]   in_prev_strain_yy,
  input  logic signed [drp_pkg::EW-1:0]   in_prev_strain_xy,
  input  logic signed [drp_pkg::SW-1:0]   in_prev_stress_xx,
  input  logic signed [drp_pkg::SW-1:0]   in_prev_stress_yy,
  input  logic signed [drp_pkg::SW-1:0]   in_prev_stress_xy,
  output logic                            out_valid,
  output logic signed [drp_pkg::SW-1:0]   out_stress_xx,
  output logic signed [drp_pkg::SW-1:0]   out_stress_yy,
  output logic signed [drp_pkg::SW-1:0]   out_stress_xy,
  output logic                            out_yielded,
  input  logic                            cfg_we,
  input  logic [drp_pkg::IDXW-1:0]        cfg_index,
  input  logic [drp_pkg::SW-1:0]          cfg_wdata
);

  drp_pkg::drp_cfg_t  cfg_r;
  drp_pkg::drp_item_t f_item, q_item;
  logic               f_push, q_pop, q_afull;
  logic               accept;

  // queue never fills since the back end drains every cycle
  assign busy   = q_afull;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lam   <= '0;
      cfg_r.shear <= '0;
      cfg_r.ixx   <= '0;
      cfg_r.iyy   <= '0;
      cfg_r.ixy   <= '0;
      cfg_r.coh   <= '0;
      cfg_r.fcos  <= drp_pkg::COS_RESET;
      cfg_r.fsin  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drp_pkg::REG_LAMBDA: cfg_r.lam   <= cfg_wdata[drp_pkg::LW-1:0];
        drp_pkg::REG_SHEAR:  cfg_r.shear <= cfg_wdata[drp_pkg::LW-1:0];
        drp_pkg::REG_IXX:    cfg_r.ixx   <= cfg_wdata;
        drp_pkg::REG_IYY:    cfg_r.iyy   <= cfg_wdata;
        drp_pkg::REG_IXY:    cfg_r.ixy   <= cfg_wdata;
        drp_pkg::REG_COH:    cfg_r.coh   <= cfg_wdata[drp_pkg::CW-1:0];
        drp_pkg::REG_COS:    cfg_r.fcos  <= cfg_wdata[drp_pkg::TW-1:0];
        drp_pkg::REG_SIN:    cfg_r.fsin  <= cfg_wdata[drp_pkg::TW-1:0];
        default: ;
      endcase
    end
  end

  // front: trial stress and yield classification
  drp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .strain_xx      (in_strain_xx),
    .strain_yy      (in_strain_yy),
    .strain_xy      (in_strain_xy),
    .prev_strain_xx (in_prev_strain_xx),
    .prev_strain_yy (in_prev_strain_yy),
    .prev_strain_xy (in_prev_strain_xy),
    .prev_stress_xx (in_prev_stress_xx),
    .prev_stress_yy (in_prev_stress_yy),
    .prev_stress_xy (in_prev_stress_xy),
    .cfg            (cfg_r),
    .push           (f_push),
    .item           (f_item)
  );

  // decoupling queue
  drp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .pop   (q_pop),
    .dout  (q_item),
    .afull (q_afull)
  );

  // back: return mapping and output
  drp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (q_pop),
    .in_item (q_item),
    .cfg     (cfg_r),
    .out_v   (out_valid),
    .o_xx    (out_stress_xx),
    .o_yy    (out_stress_yy),
    .o_xy    (out_stress_xy),
    .o_yld   (out_yielded)
  );

endmodule
